// ===== design/qer_pkg.sv =====
// constants, payload types and status codes shared by the quadratic root pipeline
`timescale 1ns / 1ps
package qer_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // coefficient difference, products, discriminant
  localparam int AW   = COEF_WIDTH + 1;
  localparam int PW   = 2 * AW;
  localparam int DW   = 2 * COEF_WIDTH + 4;
  // square root: one result bit per stage
  localparam int SQN  = DW / 2;
  localparam int SW   = SQN;
  localparam int RW   = SW + 3;
  // division: one quotient bit per stage
  localparam int SUMW = COEF_WIDTH + 3;
  localparam int NW   = SUMW + FRAC_BITS;
  localparam int DENW = COEF_WIDTH + 2;

  localparam int IN_BYTES  = (6 * COEF_WIDTH + 7) / 8;
  localparam int OUT_BYTES = (COEF_WIDTH + 7) / 8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_UNIQUE = 2'd1;
  localparam logic [1:0] ST_NO_REAL   = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  typedef struct packed {
    logic                  special;
    logic [1:0]            st;
    logic                  quad;
    logic signed [AW-1:0]  a;
    logic signed [AW-1:0]  b;
    logic signed [AW-1:0]  c;
    logic [DW-1:0]         dsh;
    logic [RW-1:0]         rem;
    logic [SW-1:0]         root;
  } sq_t;

  typedef struct packed {
    logic                  special;
    logic [1:0]            st;
    logic                  neg;
    logic [NW-1:0]         num;
    logic [DENW-1:0]       den;
    logic [DENW:0]         rem;
    logic [NW-1:0]         q;
  } dv_t;

endpackage

// ===== design/quadratic_equation_root_top.sv =====
// real root of left(x) = right(x) for two second-degree expressions, pipelined
`timescale 1ns / 1ps
//  channel | direction | tdata (low bit up)                        | tuser
//  in_     | in        | left_sq, left_lin, left_const,            | -
//          |           | right_sq, right_lin, right_const          |
//  out_    | out       | root                                      | status
//
//  one transaction enters per cycle while out_ does not stall; the pipeline depth is
//  set by the bit-per-stage square root and restoring divider
//  the whole pipeline advances together; a stall on out_ holds every stage
//  rst_n (synchronous) clears only the stage valid bits
module quadratic_equation_root_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // left_sq, left_lin, left_const, right_sq, right_lin, right_const
  input  logic [qer_pkg::IN_BYTES*8-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // root
  output logic [qer_pkg::OUT_BYTES*8-1:0]   out_tdata,
  // status
  output logic [1:0]                        out_tuser
);
  import qer_pkg::*;

  localparam int CW = COEF_WIDTH;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: differences
  logic                 v1_r;
  logic signed [AW-1:0] a1_r, b1_r, c1_r;
  logic signed [AW-1:0] a1_nxt, b1_nxt, c1_nxt;

  always_comb begin
    a1_nxt = AW'($signed(in_tdata[0*CW +: CW])) - AW'($signed(in_tdata[3*CW +: CW]));
    b1_nxt = AW'($signed(in_tdata[1*CW +: CW])) - AW'($signed(in_tdata[4*CW +: CW]));
    c1_nxt = AW'($signed(in_tdata[2*CW +: CW])) - AW'($signed(in_tdata[5*CW +: CW]));
  end

  // stage 2: magnitude products
  logic                 v2_r;
  logic signed [AW-1:0] a2_r, b2_r, c2_r;
  logic [PW-1:0]        pbb2_r, pac2_r;
  logic                 acneg2_r, az2_r, bz2_r;
  logic [AW-1:0]        ma, mb, mc;

  always_comb begin
    ma = a1_r[AW-1] ? AW'(-a1_r) : AW'(a1_r);
    mb = b1_r[AW-1] ? AW'(-b1_r) : AW'(b1_r);
    mc = c1_r[AW-1] ? AW'(-c1_r) : AW'(c1_r);
  end

  // stage 3: discriminant and special cases
  logic signed [DW-1:0] d_nxt;
  logic [DW-1:0]        p4;
  sq_t                  sq_r [0:SQN];
  sq_t                  sq0_nxt;
  logic                 sqv_r [0:SQN];

  always_comb begin
    p4 = DW'({pac2_r, 2'b00});
    d_nxt = acneg2_r ? $signed(DW'(pbb2_r) + p4) : $signed(DW'(pbb2_r) - p4);
    sq0_nxt.quad    = !az2_r;
    sq0_nxt.special = (az2_r && bz2_r) || (!az2_r && d_nxt[DW-1]);
    sq0_nxt.st      = (az2_r && bz2_r) ? ST_NO_UNIQUE :
                      (!az2_r && d_nxt[DW-1]) ? ST_NO_REAL : ST_OK;
    sq0_nxt.a       = a2_r;
    sq0_nxt.b       = b2_r;
    sq0_nxt.c       = c2_r;
    sq0_nxt.dsh     = d_nxt;
    sq0_nxt.rem     = '0;
    sq0_nxt.root    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      sqv_r[0] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      sqv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= a1_nxt;
      b1_r <= b1_nxt;
      c1_r <= c1_nxt;
      a2_r <= a1_r;
      b2_r <= b1_r;
      c2_r <= c1_r;
      pbb2_r <= mb * mb;
      pac2_r <= ma * mc;
      acneg2_r <= a1_r[AW-1] ^ c1_r[AW-1];
      az2_r <= (a1_r == '0);
      bz2_r <= (b1_r == '0);
      sq_r[0] <= sq0_nxt;
    end
  end

  // square root, two radicand bits per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    logic [RW-1:0] rem_w, trial;
    logic          ge;
    sq_t           nxt;

    always_comb begin
      rem_w = {sq_r[k].rem[RW-3:0], sq_r[k].dsh[DW-1 -: 2]};
      trial = RW'({sq_r[k].root, 2'b01});
      ge    = (rem_w >= trial);
      nxt      = sq_r[k];
      nxt.dsh  = {sq_r[k].dsh[DW-3:0], 2'b00};
      nxt.rem  = ge ? rem_w - trial : rem_w;
      nxt.root = {sq_r[k].root[SW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k+1] <= 1'b0;
      end else if (adv) begin
        sqv_r[k+1] <= sqv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1] <= nxt;
      end
    end
  end

  // numerator and denominator setup
  sq_t                    sqo;
  logic signed [SUMW-1:0] numsig;
  logic signed [DENW-1:0] densig;
  dv_t                    dv_r [0:NW];
  dv_t                    dv0_nxt;
  logic                   dvv_r [0:NW];
  logic [SUMW-1:0]        nmag;

  always_comb begin
    sqo = sq_r[SQN];
    numsig = sqo.quad ? $signed(SUMW'(sqo.root)) - SUMW'(sqo.b) : -SUMW'(sqo.c);
    densig = sqo.quad ? $signed({sqo.a, 1'b0}) : DENW'(sqo.b);
    nmag   = numsig[SUMW-1] ? SUMW'(-numsig) : SUMW'(numsig);
    dv0_nxt.special = sqo.special;
    dv0_nxt.st      = sqo.st;
    dv0_nxt.neg     = numsig[SUMW-1] ^ densig[DENW-1];
    dv0_nxt.num     = {nmag, {FRAC_BITS{1'b0}}};
    dv0_nxt.den     = densig[DENW-1] ? DENW'(-densig) : DENW'(densig);
    dv0_nxt.rem     = '0;
    dv0_nxt.q       = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r[0] <= 1'b0;
    end else if (adv) begin
      dvv_r[0] <= sqv_r[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DENW:0] rem_w, den_w;
    logic          ge;
    dv_t           nxt;

    always_comb begin
      rem_w = {dv_r[k].rem[DENW-1:0], dv_r[k].num[NW-1]};
      den_w = {1'b0, dv_r[k].den};
      ge    = (rem_w >= den_w);
      nxt     = dv_r[k];
      nxt.num = {dv_r[k].num[NW-2:0], 1'b0};
      nxt.rem = ge ? rem_w - den_w : rem_w;
      nxt.q   = {dv_r[k].q[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dvv_r[k+1] <= dvv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= nxt;
      end
    end
  end

  // saturation and output register
  dv_t           dvo;
  logic [CW-1:0] root_nxt, root_r;
  logic [1:0]    st_nxt, st_r;
  logic          ov_r;
  logic          sat_pos, sat_neg;

  always_comb begin
    dvo = dv_r[NW];
    sat_pos = (dvo.q[NW-1:CW-1] != '0);
    sat_neg = (dvo.q[NW-1:CW] != '0) || (dvo.q[CW-1] && (dvo.q[CW-2:0] != '0));
    if (dvo.special) begin
      root_nxt = '0;
      st_nxt   = dvo.st;
    end else if (!dvo.neg) begin
      root_nxt = sat_pos ? {1'b0, {(CW-1){1'b1}}} : dvo.q[CW-1:0];
      st_nxt   = sat_pos ? ST_SAT : ST_OK;
    end else begin
      root_nxt = sat_neg ? {1'b1, {(CW-1){1'b0}}} : CW'(-dvo.q[CW-1:0]);
      st_nxt   = sat_neg ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dvv_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root_r <= root_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = (OUT_BYTES*8)'(root_r);
  assign out_tuser  = st_r;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NO_UNIQUE || out_tuser == ST_NO_REAL)
      |-> root_r == '0)
    else $error("error status with nonzero root");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SAT
      |-> root_r == {1'b0, {(CW-1){1'b1}}} || root_r == {1'b1, {(CW-1){1'b0}}})
    else $error("saturated status without rail value");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted transaction not captured");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dvv_r[NW]) && $stable(sqv_r[SQN]) && $stable(v1_r))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== test/quadratic_equation_root_checker.sv =====
// checker for the quadratic root block: predicts each root and compares transactions
`timescale 1ns / 1ps
module quadratic_equation_root_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [qer_pkg::IN_BYTES*8-1:0]      in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [qer_pkg::OUT_BYTES*8-1:0]     out_tdata,
  input  logic [1:0]                          out_tuser,
  output int                                  fail_count,
  output int                                  pending_roots,
  output int                                  roots_seen,
  output int                                  sat_seen,
  output int                                  noreal_seen,
  output int                                  nouniq_seen
);
  import qer_pkg::*;

  typedef struct packed {
    logic [COEF_WIDTH-1:0] root;
    logic [1:0]            status;
  } root_t;

  root_t expected_roots[$];

  function automatic logic signed [COEF_WIDTH-1:0] coef(input logic [IN_BYTES*8-1:0] d,
                                                       input int idx);
    coef = d[idx*COEF_WIDTH +: COEF_WIDTH];
  endfunction

  // exact wide arithmetic; isqrt floors, division truncates towards zero
  function automatic root_t solve_root(input logic [IN_BYTES*8-1:0] d);
    logic signed [255:0] a, b, c, disc, num, den, q, s, maxpos, minneg;
    logic [255:0] n;
    root_t r;
    a = coef(d, 0) - coef(d, 3);
    b = coef(d, 1) - coef(d, 4);
    c = coef(d, 2) - coef(d, 5);
    maxpos = (256'sd1 <<< (COEF_WIDTH - 1)) - 1;
    minneg = -(256'sd1 <<< (COEF_WIDTH - 1));
    r.root = '0;
    r.status = ST_OK;
    if (a == 0) begin
      if (b == 0) begin
        r.status = ST_NO_UNIQUE;
        return r;
      end
      num = (-c) <<< FRAC_BITS;
      den = b;
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        r.status = ST_NO_REAL;
        return r;
      end
      n = disc;
      s = 0;
      for (int i = 127; i >= 0; i--) begin
        if ((s | (256'sd1 <<< i)) * (s | (256'sd1 <<< i)) <= n) s = s | (256'sd1 <<< i);
      end
      num = (s - b) <<< FRAC_BITS;
      den = 2 * a;
    end
    q = num / den;
    if (q > maxpos) begin
      r.root = maxpos[COEF_WIDTH-1:0];
      r.status = ST_SAT;
    end else if (q < minneg) begin
      r.root = minneg[COEF_WIDTH-1:0];
      r.status = ST_SAT;
    end else begin
      r.root = q[COEF_WIDTH-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    roots_seen = 0;
    sat_seen = 0;
    noreal_seen = 0;
    nouniq_seen = 0;
  end

  assign pending_roots = expected_roots.size();

  always @(posedge clk) begin
    root_t want;
    if (rst_n && in_tvalid && in_tready) expected_roots.push_back(solve_root(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      roots_seen++;
      case (out_tuser)
        ST_SAT:       sat_seen++;
        ST_NO_REAL:   noreal_seen++;
        ST_NO_UNIQUE: nouniq_seen++;
        default: ;
      endcase
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_tdata), 64'(0));
      end else begin
        want = expected_roots.pop_front();
        if (out_tdata[COEF_WIDTH-1:0] !== want.root)
          report_mismatch("root", 64'(out_tdata), 64'(want.root));
        if (out_tuser !== want.status)
          report_mismatch("status", 64'(out_tuser), 64'(want.status));
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
// top of the quadratic root testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import qer_pkg::*;

  localparam int LATENCY = SQN + NW + 5;
  localparam int RANDOM_ITEMS = 700;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_BYTES*8-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BYTES*8-1:0] out_tdata;
  logic [1:0] out_tuser;
  int fail_count, pending_roots, roots_seen, sat_seen, noreal_seen, nouniq_seen;
  logic long_hold = 1'b0;
  logic stim_done = 1'b0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quadratic_equation_root_top uut (.*);

  quadratic_equation_root_checker checker_i (.*);

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: rand_coef = $urandom;
      1: rand_coef = $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      2: rand_coef = {$urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF};
      3: rand_coef = 32'($signed($urandom_range(0, 16) - 8)) <<< 16;
      4: rand_coef = $urandom_range(0, 7) - 3;
      default: rand_coef = $urandom_range(0, 32'h10_0000) - 32'h8_0000;
    endcase
  endfunction

  // tvalid stays high after the accepting edge; the next call or the caller drops it
  task automatic send_equation(input logic [31:0] ls, ll, lc, rs, rl, rc);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 4) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {rc, rl, rs, lc, ll, ls};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_free_run(input int count);
    // no gaps: back-to-back transactions
    for (int i = 0; i < count; i++) begin
      in_tvalid <= 1'b1;
      in_tdata <= {rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
  endtask

  // receiver: random stalls, with one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d roots outstanding", pending_roots);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [31:0] mx, mn, one;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: linear, degenerate, no real root, saturation, extremes
    send_equation(0, one, -one, 0, 0, 0);
    send_equation(one, 0, 0, one, 0, 5);
    send_equation(one, 0, one, 0, 0, 0);
    send_equation(one, 0, -(4 * one), 0, 0, 0);
    send_equation(1, mx, mx, 0, 0, 0);
    send_equation(0, 1, mx, 0, 0, mn);
    send_equation(mx, mx, mx, mn, mn, mn);
    send_equation(mn, mn, mn, mx, mx, mx);
    send_equation(mn, 0, mx, 0, 0, 0);
    send_equation(mx, mn, 0, 0, 0, mx);
    send_equation(0, 0, 0, 0, 0, 0);
    send_equation(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    send_equation(one, -(2 * one), one, 0, 0, 0);
    send_equation(-one, 3 * one, 2 * one, one, one, one);
    send_equation(0, mn, 0, 0, mx, 0);
    send_equation(2 * one, 0, -(8 * one), one, 0, 0);
    in_tvalid <= 1'b0;
    // pause until everything has drained
    while (pending_roots != 0) @(posedge clk);
    long_hold = 1'b1;
    send_free_run(3 * LATENCY);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_equation(rand_coef(), rand_coef(), rand_coef(),
                    rand_coef(), rand_coef(), rand_coef());
      if (i == RANDOM_ITEMS / 2) send_free_run(50);
    end
    in_tvalid <= 1'b0;
    while (pending_roots != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d roots: %0d saturated, %0d without real root, %0d degenerate",
             roots_seen, sat_seen, noreal_seen, nouniq_seen);
    $display("stimulus covered extremes, back-to-back bursts and a long output stall");
    if (fail_count == 0 && pending_roots == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/qer_pkg.sv
design/quadratic_equation_root_top.sv
test/quadratic_equation_root_checker.sv
test/testbench.sv
